/* src/dtrs_pkg.sv */
// Shared types, constants and control store for the dual triangle synth.
// No dependencies; imported by the datapath, the top level and the test.
package dtrs_pkg;

  localparam int PHASE_BITS  = 24;
  localparam int ENV_FRAC    = 24;
  localparam int ENV_W       = ENV_FRAC + 1;
  localparam int PITCH_W     = 16;
  localparam int STEP_W      = 20;
  localparam int GAIN_W      = 16;
  localparam int RATE_W      = 24;
  localparam int TRI_W       = 17;
  localparam int SAMPLE_W    = 16;

  // base step (Q0.24) times pitch (Q2.14) is Q.38
  localparam int STEP_SUM_W  = 38;
  localparam int STEP_SHIFT  = STEP_SUM_W - PHASE_BITS;
  localparam int ENV_PROD_W  = ENV_W + RATE_W;
  // Q1.15 * Q0.16 * Q1.24 -> Q.55, back to Q1.15
  localparam int MIX_SHIFT   = 40;

  // shared multiplier
  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 26;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;

  localparam logic [PITCH_W-1:0] PITCH_LO = 16'd8192;
  localparam logic [PITCH_W-1:0] PITCH_HI = 16'd32768;
  localparam logic [ENV_W-1:0]   ENV_ONE  = {1'b1, {ENV_FRAC{1'b0}}};

  // register map (byte address = 4 * index)
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_A  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BASE_B  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_A  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_B  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SILENCE = 3'd7;

  typedef struct packed {
    logic                enable;
    logic [STEP_W-1:0]   base_a;
    logic [STEP_W-1:0]   base_b;
    logic [GAIN_W-1:0]   gain_a;
    logic [GAIN_W-1:0]   gain_b;
    logic [RATE_W-1:0]   attack;
    logic [RATE_W-1:0]   rel_rate;
    logic [ENV_W-1:0]    silence;
  } cfg_t;

  typedef enum logic [2:0] {
    M_NONE, M_ENV, M_STEPA, M_STEPB, M_TRIA, M_TRIB, M_MIX
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_ENV, OP_PHA, OP_PHB, OP_ACCSET, OP_ACCADD, OP_EMIT, OP_ZERO
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT, C_ALWAYS, C_NOIN, C_IDLE
  } cond_t;

  typedef struct packed {
    mul_sel_t mul;
    op_t      op;
  } dp_ctrl_t;

  typedef struct packed {
    logic                       idle;
    logic signed [SAMPLE_W-1:0] sample;
  } dp_stat_t;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd8;
  localparam logic [PC_W-1:0] PC_ZERO  = 4'd9;

  typedef struct packed {
    cond_t             cond;
    logic [PC_W-1:0]   target;
    mul_sel_t          mul;
    op_t               op;
  } ucode_t;

  // Microprogram. The multiplier result lands in a register, so each op
  // consumes the product started by the step before it.
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t u;
    u = '{cond: C_NEXT, target: PC_WAIT, mul: M_NONE, op: OP_NOP};
    case (pc)
      PC_WAIT: begin
        u.cond = C_NOIN;   u.target = PC_WAIT; u.op = OP_LOAD;
      end
      PC_CHECK: begin
        u.cond = C_IDLE;   u.target = PC_ZERO; u.mul = M_ENV;
      end
      4'd2: begin u.mul = M_STEPA; u.op = OP_ENV;    end
      4'd3: begin u.mul = M_STEPB; u.op = OP_PHA;    end
      4'd4: begin u.mul = M_TRIA;  u.op = OP_PHB;    end
      4'd5: begin u.mul = M_TRIB;  u.op = OP_ACCSET; end
      4'd6: begin u.op = OP_ACCADD; end
      4'd7: begin u.mul = M_MIX; end
      PC_EMIT: begin
        u.cond = C_ALWAYS; u.target = PC_WAIT; u.op = OP_EMIT;
      end
      PC_ZERO: begin
        u.cond = C_ALWAYS; u.target = PC_WAIT; u.op = OP_ZERO;
      end
      default: begin
        u.cond = C_ALWAYS; u.target = PC_WAIT;
      end
    endcase
    return u;
  endfunction

  // Q1.15 triangle, -32768..32768
  function automatic logic signed [TRI_W-1:0] tri_wave(logic [PHASE_BITS-1:0] ph);
    logic [PHASE_BITS-1:0] half;
    logic [PHASE_BITS-1:0] d;
    logic [PHASE_BITS+1:0] sh;
    logic [TRI_W:0]        t;
    half = {1'b1, {(PHASE_BITS-1){1'b0}}};
    d    = (ph >= half) ? ph - half : half - ph;
    sh   = {d, 2'b00} >> (PHASE_BITS - 15);
    t    = {1'b0, sh[TRI_W-1:0]} - {3'b001, {(TRI_W-2){1'b0}}};
    return t[TRI_W-1:0];
  endfunction

endpackage

/* src/dtrs_datapath.sv */
// Datapath: oscillator and envelope state, one shared multiplier, mix rounding.
// Depends on dtrs_pkg; driven step by step by the sequencer in the top level.
module dtrs_datapath
  import dtrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  dp_ctrl_t             ctrl,
  input  logic                 in_key,
  input  logic [PITCH_W-1:0]   in_pitch,
  output dp_stat_t             stat
);

  logic [PHASE_BITS-1:0]      phase_a_r, phase_a_nxt;
  logic [PHASE_BITS-1:0]      phase_b_r, phase_b_nxt;
  logic [ENV_W-1:0]           env_r, env_nxt;
  logic                       key_r, key_nxt;
  logic [PITCH_W-1:0]         pitch_r, pitch_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [MUL_A_W-1:0]  acc_r, acc_nxt;

  logic [ENV_W-1:0]           dmag;
  logic [RATE_W-1:0]          rate;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [TRI_W-1:0]    tri_a, tri_b;

  logic [ENV_PROD_W:0]        env_sum;
  logic [ENV_W:0]             env_q;
  logic [ENV_W+1:0]           env_up;
  logic [STEP_SUM_W-1:0]      step_sum;
  logic [PHASE_BITS-1:0]      step;

  logic                       mix_neg;
  logic [PROD_W-1:0]          mix_mag;
  logic [PROD_W:0]            mix_sum;
  logic [PROD_W-MIX_SHIFT:0]  mix_q;
  logic signed [SAMPLE_W-1:0] sample;

  assign dmag  = key_r ? ENV_ONE - env_r : env_r;
  assign rate  = key_r ? cfg.attack : cfg.rel_rate;
  assign tri_a = tri_wave(phase_a_r);
  assign tri_b = tri_wave(phase_b_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul)
      M_ENV: begin
        mul_a = {{(MUL_A_W-ENV_W){1'b0}}, dmag};
        mul_b = {{(MUL_B_W-RATE_W){1'b0}}, rate};
      end
      M_STEPA: begin
        mul_a = {{(MUL_A_W-STEP_W){1'b0}}, cfg.base_a};
        mul_b = {{(MUL_B_W-PITCH_W){1'b0}}, pitch_r};
      end
      M_STEPB: begin
        mul_a = {{(MUL_A_W-STEP_W){1'b0}}, cfg.base_b};
        mul_b = {{(MUL_B_W-PITCH_W){1'b0}}, pitch_r};
      end
      M_TRIA: begin
        mul_a = {{(MUL_A_W-TRI_W){tri_a[TRI_W-1]}}, tri_a};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_a};
      end
      M_TRIB: begin
        mul_a = {{(MUL_A_W-TRI_W){tri_b[TRI_W-1]}}, tri_b};
        mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_b};
      end
      M_MIX: begin
        mul_a = acc_r;
        mul_b = {{(MUL_B_W-ENV_W){1'b0}}, env_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = (ctrl.mul == M_NONE) ? prod_r : mul_a * mul_b;

  // envelope: magnitude of step rounded half away from zero, then clamp
  assign env_sum = {1'b0, prod_r[ENV_PROD_W-1:0]} + ((ENV_PROD_W+1)'(1) << (ENV_FRAC-1));
  assign env_q   = env_sum[ENV_PROD_W:ENV_FRAC];
  assign env_up  = {2'b00, env_r} + {1'b0, env_q};

  // phase step rounded half up into Q0.PHASE_BITS
  assign step_sum = prod_r[STEP_SUM_W-1:0] + (STEP_SUM_W'(1) << (STEP_SHIFT-1));
  assign step     = step_sum[STEP_SUM_W-1:STEP_SHIFT];

  // mix: sign-magnitude rounding, then saturate to Q1.15
  assign mix_neg = prod_r[PROD_W-1];
  assign mix_mag = mix_neg ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign mix_sum = {1'b0, mix_mag} + ((PROD_W+1)'(1) << (MIX_SHIFT-1));
  assign mix_q   = mix_sum[PROD_W:MIX_SHIFT];

  always_comb begin
    if (mix_neg) begin
      if (mix_q >= (PROD_W-MIX_SHIFT+1)'(32768)) sample = 16'sh8000;
      else sample = -$signed(mix_q[SAMPLE_W-1:0]);
    end else begin
      if (mix_q > (PROD_W-MIX_SHIFT+1)'(32767)) sample = 16'sh7fff;
      else sample = $signed(mix_q[SAMPLE_W-1:0]);
    end
  end

  assign stat.sample = sample;
  assign stat.idle   = !cfg.enable || (!key_r && (env_r <= cfg.silence));

  always_comb begin
    phase_a_nxt = phase_a_r;
    phase_b_nxt = phase_b_r;
    env_nxt     = env_r;
    key_nxt     = key_r;
    pitch_nxt   = pitch_r;
    acc_nxt     = acc_r;
    case (ctrl.op)
      OP_LOAD: begin
        key_nxt = in_key;
        if (in_pitch < PITCH_LO)      pitch_nxt = PITCH_LO;
        else if (in_pitch > PITCH_HI) pitch_nxt = PITCH_HI;
        else                          pitch_nxt = in_pitch;
      end
      OP_ENV: begin
        if (key_r) begin
          env_nxt = (env_up > {2'b00, ENV_ONE}) ? ENV_ONE : env_up[ENV_W-1:0];
        end else begin
          env_nxt = (env_q > {1'b0, env_r}) ? '0 : env_r - env_q[ENV_W-1:0];
        end
      end
      OP_PHA:    phase_a_nxt = phase_a_r + step;
      OP_PHB:    phase_b_nxt = phase_b_r + step;
      OP_ACCSET: acc_nxt     = prod_r[MUL_A_W-1:0];
      OP_ACCADD: acc_nxt     = acc_r + prod_r[MUL_A_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r <= '0;
      phase_b_r <= '0;
      env_r     <= '0;
    end else begin
      phase_a_r <= phase_a_nxt;
      phase_b_r <= phase_b_nxt;
      env_r     <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    pitch_r <= pitch_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
  end

endmodule

/* src/dual_triangle_rumble_synth_core.sv */
// Top level: APB register file, stream ports, microcoded sequencer.
// Depends on dtrs_pkg and dtrs_datapath.
//
// Two triangle oscillators (24-bit phase accumulators, step = base step times
// clamped pitch) are mixed by their gains and scaled by an attack/release
// envelope; one output sample per input tick. A running tick passes through
// eight microcode steps after the accept step (set by the one shared multiplier
// being used six times in sequence); an idle tick (disabled, or released with
// the envelope at or below the silence level) goes from the check step straight
// to the zero step. A full output register that is not taken holds the
// sequencer at its final step. The output register lets the result wait while
// the next tick is accepted.
module dual_triangle_rumble_synth_core
  import dtrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [0] key_on, [16:1] pitch, [23:17] zero
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [15:0] sample, [16] active, [23:17] zero
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t                       cfg_r, cfg_nxt;
  logic [PC_W-1:0]            pc_r, pc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_active_r, out_active_nxt;

  ucode_t                     uc;
  dp_ctrl_t                   ctrl;
  dp_stat_t                   stat;
  logic                       in_xfer;
  logic                       emits;
  logic                       hold;
  logic                       take;
  logic                       cfg_wr;
  logic [REG_IDX_W-1:0]       reg_idx;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_ENABLE:  cfg_nxt.enable   = cfg_pwdata[0];
        REG_BASE_A:  cfg_nxt.base_a   = cfg_pwdata[STEP_W-1:0];
        REG_BASE_B:  cfg_nxt.base_b   = cfg_pwdata[STEP_W-1:0];
        REG_GAIN_A:  cfg_nxt.gain_a   = cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_B:  cfg_nxt.gain_b   = cfg_pwdata[GAIN_W-1:0];
        REG_ATTACK:  cfg_nxt.attack   = cfg_pwdata[RATE_W-1:0];
        REG_RELEASE: cfg_nxt.rel_rate = cfg_pwdata[RATE_W-1:0];
        REG_SILENCE: cfg_nxt.silence  = cfg_pwdata[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENABLE:  cfg_prdata = {31'd0, cfg_r.enable};
      REG_BASE_A:  cfg_prdata = {{(32-STEP_W){1'b0}}, cfg_r.base_a};
      REG_BASE_B:  cfg_prdata = {{(32-STEP_W){1'b0}}, cfg_r.base_b};
      REG_GAIN_A:  cfg_prdata = {{(32-GAIN_W){1'b0}}, cfg_r.gain_a};
      REG_GAIN_B:  cfg_prdata = {{(32-GAIN_W){1'b0}}, cfg_r.gain_b};
      REG_ATTACK:  cfg_prdata = {{(32-RATE_W){1'b0}}, cfg_r.attack};
      REG_RELEASE: cfg_prdata = {{(32-RATE_W){1'b0}}, cfg_r.rel_rate};
      REG_SILENCE: cfg_prdata = {{(32-ENV_W){1'b0}}, cfg_r.silence};
      default:     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable   <= 1'b0;
      cfg_r.base_a   <= 20'd19022;
      cfg_r.base_b   <= 20'd26631;
      cfg_r.gain_a   <= 16'd2949;
      cfg_r.gain_b   <= 16'd1638;
      cfg_r.attack   <= 24'd7609;
      cfg_r.rel_rate <= 24'd3458;
      cfg_r.silence  <= 25'd8389;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- sequencer ----------------
  assign uc        = ucode_rom(pc_r);
  assign in_tready = (pc_r == PC_WAIT);
  assign in_xfer   = in_tvalid && in_tready;

  assign emits = (uc.op == OP_EMIT) || (uc.op == OP_ZERO);
  // final step waits for room in the output register
  assign hold  = emits && out_valid_r && !out_tready;

  always_comb begin
    ctrl.mul = uc.mul;
    ctrl.op  = uc.op;
    if (hold || (uc.op == OP_LOAD && !in_xfer)) ctrl.op = OP_NOP;
  end

  always_comb begin
    case (uc.cond)
      C_NEXT:   take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_NOIN:   take = !in_xfer;
      C_IDLE:   take = stat.idle;
      default:  take = 1'b1;
    endcase
    if (hold)      pc_nxt = pc_r;
    else if (take) pc_nxt = uc.target;
    else           pc_nxt = pc_r + PC_W'(1);
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;
    if (emits && !hold) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = (uc.op == OP_EMIT) ? stat.sample : '0;
      out_active_nxt = (uc.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_active_r, out_sample_r};

  dtrs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .ctrl     (ctrl),
    .in_key   (in_tdata[0]),
    .in_pitch (in_tdata[16:1]),
    .stat     (stat)
  );

endmodule

/* src/dtrs_checker.sv */
// Port-level checks for dual_triangle_rumble_synth_core, bound to the top level.
// Depends on nothing but the top level's ports.
module dtrs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [23:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [4:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one tick at a time: ready drops right after a transfer
  a_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // an idle tick carries a zero sample
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[15:0] == 16'd0)
    else $error("inactive result with nonzero sample");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:17] == 7'd0)
    else $error("result padding not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind dual_triangle_rumble_synth_core dtrs_checker u_dtrs_checker (.*);

/* dv/dual_triangle_rumble_synth_core_test.sv */
// Self-checking test for dual_triangle_rumble_synth_core: APB setup, stream ticks in,
// samples out, each checked against a cycle-free fixed-point predictor of the synth.
// Depends on dtrs_pkg (register indexes, widths, cfg_t) and the core RTL.
`timescale 1ns / 100ps

module dual_triangle_rumble_synth_core_test;
  import dtrs_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES          = 12;
  localparam int TICKS_PER_PHASE = 100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
  } tick_result_t;

  class synth_scoreboard;
    cfg_t                  regs;
    logic [PHASE_BITS-1:0] phase_a;
    logic [PHASE_BITS-1:0] phase_b;
    logic [ENV_W-1:0]      env_level;
    tick_result_t          due_samples[$];
    int                    errors;

    function new();
      regs = '{enable: 1'b0, base_a: 20'd19022, base_b: 20'd26631, gain_a: 16'd2949,
               gain_b: 16'd1638, attack: 24'd7609, rel_rate: 24'd3458, silence: 25'd8389};
      phase_a   = '0;
      phase_b   = '0;
      env_level = '0;
      errors    = 0;
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_ENABLE:  regs.enable   = value[0];
        REG_BASE_A:  regs.base_a   = value[STEP_W-1:0];
        REG_BASE_B:  regs.base_b   = value[STEP_W-1:0];
        REG_GAIN_A:  regs.gain_a   = value[GAIN_W-1:0];
        REG_GAIN_B:  regs.gain_b   = value[GAIN_W-1:0];
        REG_ATTACK:  regs.attack   = value[RATE_W-1:0];
        REG_RELEASE: regs.rel_rate = value[RATE_W-1:0];
        REG_SILENCE: regs.silence  = value[ENV_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_ENABLE:  return 32'(regs.enable);
        REG_BASE_A:  return 32'(regs.base_a);
        REG_BASE_B:  return 32'(regs.base_b);
        REG_GAIN_A:  return 32'(regs.gain_a);
        REG_GAIN_B:  return 32'(regs.gain_b);
        REG_ATTACK:  return 32'(regs.attack);
        REG_RELEASE: return 32'(regs.rel_rate);
        default:     return 32'(regs.silence);
      endcase
    endfunction

    // Q1.15 triangle, -32768..32768, from a Q0.24 phase
    function longint tri_level(logic [PHASE_BITS-1:0] ph);
      longint half, d, p;
      half = longint'(1) << (PHASE_BITS - 1);
      p    = ph;
      d    = (p >= half) ? p - half : half - p;
      return ((4 * d) >> (PHASE_BITS - 15)) - 32768;
    endfunction

    function void note_tick(logic key, logic [PITCH_W-1:0] pitch);
      logic [PITCH_W-1:0] p;
      longint env, diff, mag, q, rate, mix, s, pl, bl, step, ga, gb;
      tick_result_t r;
      p = pitch;
      if (p < PITCH_LO) p = PITCH_LO;
      if (p > PITCH_HI) p = PITCH_HI;
      if (!regs.enable || (!key && env_level <= regs.silence)) begin
        r.sample = '0;
        r.active = 1'b0;
        due_samples.push_back(r);
        return;
      end
      // envelope eases toward full scale or zero, magnitude rounded half away
      env  = env_level;
      rate = key ? regs.attack : regs.rel_rate;
      diff = key ? (longint'(1) << ENV_FRAC) - env : -env;
      mag  = (diff < 0) ? -diff : diff;
      q    = (mag * rate + (longint'(1) << (ENV_FRAC - 1))) >> ENV_FRAC;
      env  = (diff < 0) ? env - q : env + q;
      if (env < 0) env = 0;
      if (env > (longint'(1) << ENV_FRAC)) env = longint'(1) << ENV_FRAC;
      env_level = env[ENV_W-1:0];

      pl = p;
      bl = regs.base_a;
      step = (bl * pl + (longint'(1) << (STEP_SHIFT - 1))) >> STEP_SHIFT;
      phase_a = phase_a + step[PHASE_BITS-1:0];
      bl = regs.base_b;
      step = (bl * pl + (longint'(1) << (STEP_SHIFT - 1))) >> STEP_SHIFT;
      phase_b = phase_b + step[PHASE_BITS-1:0];

      ga  = regs.gain_a;
      gb  = regs.gain_b;
      mix = (tri_level(phase_a) * ga + tri_level(phase_b) * gb) * env;
      mag = (mix < 0) ? -mix : mix;
      q   = (mag + (longint'(1) << (MIX_SHIFT - 1))) >> MIX_SHIFT;
      if (q > 32768) q = 32768;
      s = (mix < 0) ? -q : q;
      if (s > 32767) s = 32767;
      r.sample = s[SAMPLE_W-1:0];
      r.active = 1'b1;
      due_samples.push_back(r);
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] sample, logic active);
      tick_result_t want;
      if (due_samples.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, got sample %0d active %0b",
                 $time, $signed(sample), active);
        return;
      end
      want = due_samples.pop_front();
      if (sample !== want.sample) report("sample", want.sample, $signed(sample));
      if (active !== want.active) report("active", want.active, active);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // [0] key_on, [16:1] pitch, [23:17] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [15:0] sample, [16] active, [23:17] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  synth_scoreboard board = new();
  bit jitter     = 1'b1;
  int ready_hold = 0;

  dual_triangle_rumble_synth_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Call at a falling edge; returns at a falling edge.
  task automatic send_tick(input logic key, input logic [PITCH_W-1:0] pitch);
    if (jitter && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      do repeat ($urandom_range(1, 3)) @(negedge clk);
      while ($urandom_range(0, 2) == 0);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, pitch, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_tick(key, pitch);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk);
    while (board.due_samples.size() != 0);
  endtask

  // APB write followed by a readback of the same register
  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    if (got !== board.reg_value(idx)) board.report("register readback", board.reg_value(idx), got);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // random bits above the field; the block must drop them
  function automatic logic [31:0] with_junk(logic [31:0] v, int w);
    if ($urandom_range(0, 3) == 0) return v | ($urandom() << w);
    return v;
  endfunction

  function automatic logic [31:0] pick_field(int w);
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return (32'd1 << w) - 1;
      2:       return $urandom() & ((32'd1 << (w - 1)) - 1);
      default: return $urandom() & ((32'd1 << w) - 1);
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return RATE_W'($urandom_range(0, 15));
      1:       return RATE_W'($urandom());
      5:       return '1;
      default: return RATE_W'($urandom_range(1 << 21, (1 << 24) - 1));
    endcase
  endfunction

  function automatic logic [PITCH_W-1:0] pick_pitch();
    if ($urandom_range(0, 4) == 0) return PITCH_W'($urandom_range(0, 65535));
    return PITCH_W'($urandom_range(PITCH_LO, PITCH_HI));
  endfunction

  task automatic random_config();
    logic [31:0] v;
    set_reg(REG_ENABLE, with_junk(32'($urandom_range(0, 9) != 0), 1));
    set_reg(REG_BASE_A, with_junk(pick_field(STEP_W), STEP_W));
    set_reg(REG_BASE_B, with_junk(pick_field(STEP_W), STEP_W));
    set_reg(REG_GAIN_A, with_junk(pick_field(GAIN_W), GAIN_W));
    set_reg(REG_GAIN_B, with_junk(pick_field(GAIN_W), GAIN_W));
    set_reg(REG_ATTACK, with_junk(32'(pick_rate()), RATE_W));
    set_reg(REG_RELEASE, with_junk(32'(pick_rate()), RATE_W));
    case ($urandom_range(0, 5))
      0:       v = 32'd0;
      1:       v = 32'h100_0000;
      2:       v = 32'h1FF_FFFF;
      default: v = $urandom_range(0, 32'h40_0000);
    endcase
    set_reg(REG_SILENCE, with_junk(v, ENV_W));
  endtask

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      board.check_sample(out_tdata[SAMPLE_W-1:0], out_tdata[SAMPLE_W]);

  initial begin : result_sink
    int burst;
    burst      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_tready <= 1'b0;
        ready_hold--;
      end else if (burst > 0) begin
        out_tready <= 1'b0;
        burst--;
      end else if (jitter && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        burst = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("dual_triangle_rumble_synth_core_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    logic               key;
    bit                 noisy;
    int                 sent;
    int                 run;
    logic [PITCH_W-1:0] corner_pitch [7];
    corner_pitch = '{16'd0, 16'd8191, 16'd8192, 16'd16384, 16'd32768, 16'd32769, 16'hFFFF};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    key         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // disabled out of reset: silent, state frozen
    send_tick(1'b1, 16'd0);
    send_tick(1'b1, 16'hFFFF);
    drain();
    set_reg(REG_ENABLE, 32'd1);
    // released with the envelope at zero
    send_tick(1'b0, 16'd16384);
    // pitch clamp on both ends
    foreach (corner_pitch[i]) send_tick(1'b1, corner_pitch[i]);
    drain();

    // full-scale attack, gains and base step A: one-tick attack, saturating mix
    set_reg(REG_ATTACK, 32'hFF_FFFF);
    set_reg(REG_GAIN_A, 32'hFFFF);
    set_reg(REG_GAIN_B, 32'hFFFF);
    set_reg(REG_BASE_A, 32'hF_FFFF);
    set_reg(REG_BASE_B, 32'd0);
    set_reg(REG_RELEASE, 32'd0);
    send_tick(1'b1, 16'd8192);
    send_tick(1'b1, 16'd32768);
    send_tick(1'b1, 16'd20000);
    send_tick(1'b1, 16'd12345);
    // zero release rate: the envelope cannot move
    send_tick(1'b0, 16'd16384);
    send_tick(1'b0, 16'd16384);
    drain();

    // instant release: still active on the tick it drops, idle after
    set_reg(REG_RELEASE, 32'hFF_FFFF);
    send_tick(1'b0, 16'd16384);
    send_tick(1'b0, 16'd16384);
    drain();

    // silence level above full scale: any release idles at once
    set_reg(REG_SILENCE, 32'h1FF_FFFF);
    send_tick(1'b1, 16'd16384);
    send_tick(1'b0, 16'd16384);
    send_tick(1'b0, 16'd30000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph >= PHASES - 2) jitter = 1'b0;
      random_config();
      // receiver backs off while ticks keep coming, filling the block
      if (ph == 2) ready_hold = HOLD_OFF_CYCLES;
      sent = 0;
      while (sent < TICKS_PER_PHASE) begin
        run   = $urandom_range(1, 40);
        if (run > TICKS_PER_PHASE - sent) run = TICKS_PER_PHASE - sent;
        noisy = ($urandom_range(0, 9) == 0);
        key   = ~key;
        repeat (run) begin
          send_tick(noisy ? 1'($urandom_range(0, 1)) : key, pick_pitch());
          sent++;
        end
      end
      drain();
    end

    repeat (16) @(negedge clk);
    if (board.errors == 0)
      $display("dual_triangle_rumble_synth_core_test: done, clean");
    else
      $display("dual_triangle_rumble_synth_core_test: done, errors");
    $finish;
  end

endmodule
